/* src/sfd_pkg.sv */
package sfd_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h61;
  localparam int STATUS_FIELDS = 7;
  // status field that carries the mode byte (frame byte 4)
  localparam int MODE_FIELD = 3;

  localparam logic [7:0] MODE_TASK     = 8'd1;
  localparam logic [7:0] MODE_REMOTE   = 8'd2;
  localparam logic [7:0] MODE_TAKEOVER = 8'd3;
  localparam logic [7:0] RESET_MODE    = MODE_TAKEOVER;

  localparam int TICK_W = 16;
  typedef logic [TICK_W-1:0] tick_t;

  localparam tick_t TAKEOVER_TICKS_RESET = 16'd500;
  localparam tick_t CANCEL_TICKS_RESET   = 16'd400;
  localparam tick_t ELAPSED_MAX          = 16'hFFFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic {
    CFG_TAKEOVER_TICKS = 1'b0,
    CFG_CANCEL_TICKS   = 1'b1
  } cfg_idx_e;

  typedef logic [STATUS_FIELDS-1:0][7:0] status_t;

  typedef struct packed {
    logic    is_tick;
    status_t status;
  } cmd_t;

  typedef struct packed {
    status_t status;
    logic    takeover;
    logic    cancel;
  } result_t;

  typedef struct packed {
    logic     we;
    cfg_idx_e index;
    tick_t    data;
  } cfg_wr_t;

endpackage

/* src/status_frame_deframer_takeover_events.sv */
// Status frame deframer with debounced takeover and cancel events.
//
// Input queue side: present operation_i (0 byte, 1 tick) and rx_byte_i with
// push_i; a transfer happens on a clock edge with push_i high and full_o low.
// Result queue side: while empty_o is low the oldest result sits on the
// status and event ports; a transfer happens on an edge with pop_i high.
// A result appears only for a byte that completes a valid frame (header 0x61,
// 8-bit sum of the status bytes matches the checksum byte); ticks advance the
// debounce counters and give no result.
// A frame passes a queue entry, then the result register; items ahead delay it.
// Throughput: one item per cycle while full_o is low. A front stage keeps the
// byte window and checks it, a queue of QUEUE_DEPTH entries carries frames and
// ticks to a back stage that runs the debounce logic and holds one result register.
// When the result side stalls, the queue fills and full_o rises; ticks behind
// a held frame wait their turn so event timing stays in order.
// Reset clears the window, sets the counters saturated, the previous mode to
// 3 and the debounce registers to 500 and 400 ticks. Write cfg_we_i only
// while the block is idle.
module status_frame_deframer_takeover_events import sfd_pkg::*; #(
  parameter int FRAME_BYTES = 9,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              operation_i,
  input  logic [7:0]        rx_byte_i,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        active_task_o,
  output logic [7:0]        task_done_o,
  output logic [7:0]        vehicle_status_o,
  output logic [7:0]        mode_status_o,
  output logic [7:0]        battery_level_o,
  output logic [7:0]        brush_status_o,
  output logic [7:0]        charge_status_o,
  output logic              takeover_event_o,
  output logic              cancel_event_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [TICK_W-1:0] cfg_data_i
);

  logic    queue_push, queue_full, head_valid, head_pop;
  cmd_t    queue_cmd, head_cmd;
  cfg_wr_t cfg;
  result_t result;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_idx_e'(cfg_index_i);
  assign cfg.data  = cfg_data_i;

  sfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .queue_full_i(queue_full),
    .queue_push_o(queue_push),
    .queue_cmd_o (queue_cmd)
  );

  sfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (queue_push),
    .cmd_i  (queue_cmd),
    .full_o (queue_full),
    .valid_o(head_valid),
    .cmd_o  (head_cmd),
    .pop_i  (head_pop)
  );

  sfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_valid_i(head_valid),
    .head_cmd_i  (head_cmd),
    .head_pop_o  (head_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .result_o    (result)
  );

  assign full_o           = queue_full;
  assign active_task_o    = result.status[0];
  assign task_done_o      = result.status[1];
  assign vehicle_status_o = result.status[2];
  assign mode_status_o    = result.status[3];
  assign battery_level_o  = result.status[4];
  assign brush_status_o   = result.status[5];
  assign charge_status_o  = result.status[6];
  assign takeover_event_o = result.takeover;
  assign cancel_event_o   = result.cancel;

endmodule

/* src/sfd_front.sv */
module sfd_front import sfd_pkg::*; #(
  parameter int FRAME_BYTES = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       operation_i,
  input  logic [7:0] rx_byte_i,
  input  logic       queue_full_i,
  output logic       queue_push_o,
  output cmd_t       queue_cmd_o
);

  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);

  logic [FRAME_BYTES-1:0][7:0] win_q, win_d, win_shift;
  logic [FILL_W-1:0]           fill_q, fill_d, fill_shift;
  logic [7:0]                  sum;
  logic                        frame_ok;
  logic                        accept;
  op_e                         op;
  status_t                     status;

  assign accept = push_i & ~queue_full_i;
  assign op     = op_e'(operation_i);

  // window as it stands once the incoming byte is in; index 0 is the oldest
  always_comb begin
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      win_shift[i] = win_q[i+1];
    end
    win_shift[FRAME_BYTES-1] = rx_byte_i;
    fill_shift = (fill_q == FILL_FULL) ? FILL_FULL : fill_q + FILL_W'(1);
  end

  always_comb begin
    sum = '0;
    for (int i = 1; i < FRAME_BYTES - 1; i++) begin
      sum = sum + win_shift[i];
    end
  end

  assign frame_ok = (fill_shift == FILL_FULL) && (win_shift[0] == HEADER_BYTE) &&
                    (sum == win_shift[FRAME_BYTES-1]);

  // fields that would hit the checksum or lie past the frame read as zero
  for (genvar k = 0; k < STATUS_FIELDS; k++) begin : g_status
    if (k + 2 < FRAME_BYTES) begin : g_in
      assign status[k] = win_shift[k+1];
    end else begin : g_out
      assign status[k] = '0;
    end
  end

  always_comb begin
    win_d               = win_q;
    fill_d              = fill_q;
    queue_push_o        = 1'b0;
    queue_cmd_o.is_tick = (op == OP_TICK);
    queue_cmd_o.status  = status;
    if (accept) begin
      unique case (op)
        OP_TICK: queue_push_o = 1'b1;
        OP_BYTE: begin
          if (frame_ok) begin
            queue_push_o = 1'b1;
            win_d        = '0;
            fill_d       = '0;
          end else begin
            win_d  = win_shift;
            fill_d = fill_shift;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

endmodule

/* src/sfd_queue.sv */
module sfd_queue import sfd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              wr, rd;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign wr      = push_i & ~full_o;
  assign rd      = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr && !rd) begin
      count_d = count_q + CNT_W'(1);
    end else if (rd && !wr) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* src/sfd_back.sv */
module sfd_back import sfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    head_valid_i,
  input  cmd_t    head_cmd_i,
  output logic    head_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t result_o
);

  tick_t      takeover_ticks_q, cancel_ticks_q;
  tick_t      takeover_elapsed_q, takeover_elapsed_d;
  tick_t      cancel_elapsed_q, cancel_elapsed_d;
  logic [7:0] prev_mode_q, prev_mode_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       out_transfer;
  logic       frame_take, tick_take;
  logic [7:0] mode;
  logic       takeover_fire, cancel_fire;

  assign out_transfer = pop_i & out_valid_q;
  assign head_pop_o   = head_valid_i & (head_cmd_i.is_tick | ~out_valid_q | out_transfer);
  assign tick_take    = head_pop_o & head_cmd_i.is_tick;
  assign frame_take   = head_pop_o & ~head_cmd_i.is_tick;

  assign mode = head_cmd_i.status[MODE_FIELD];

  assign takeover_fire = (prev_mode_q == MODE_REMOTE) && (mode == MODE_TAKEOVER) &&
                         (takeover_elapsed_q >= takeover_ticks_q);
  assign cancel_fire   = ((prev_mode_q == MODE_TASK) || (prev_mode_q == MODE_TAKEOVER)) &&
                         (mode == MODE_REMOTE) && (cancel_elapsed_q >= cancel_ticks_q);

  always_comb begin
    takeover_elapsed_d = takeover_elapsed_q;
    cancel_elapsed_d   = cancel_elapsed_q;
    prev_mode_d        = prev_mode_q;
    out_valid_d        = out_valid_q & ~out_transfer;
    out_d              = out_q;
    if (tick_take) begin
      // saturate at the top
      if (takeover_elapsed_q != ELAPSED_MAX) begin
        takeover_elapsed_d = takeover_elapsed_q + TICK_W'(1);
      end
      if (cancel_elapsed_q != ELAPSED_MAX) begin
        cancel_elapsed_d = cancel_elapsed_q + TICK_W'(1);
      end
    end
    if (frame_take) begin
      if (takeover_fire) begin
        takeover_elapsed_d = '0;
      end
      if (cancel_fire) begin
        cancel_elapsed_d = '0;
      end
      prev_mode_d     = mode;
      out_valid_d     = 1'b1;
      out_d.status    = head_cmd_i.status;
      out_d.takeover  = takeover_fire;
      out_d.cancel    = cancel_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      takeover_ticks_q <= TAKEOVER_TICKS_RESET;
      cancel_ticks_q   <= CANCEL_TICKS_RESET;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        CFG_TAKEOVER_TICKS: takeover_ticks_q <= cfg_i.data;
        CFG_CANCEL_TICKS:   cancel_ticks_q   <= cfg_i.data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      takeover_elapsed_q <= ELAPSED_MAX;
      cancel_elapsed_q   <= ELAPSED_MAX;
      prev_mode_q        <= RESET_MODE;
      out_valid_q        <= 1'b0;
    end else begin
      takeover_elapsed_q <= takeover_elapsed_d;
      cancel_elapsed_q   <= cancel_elapsed_d;
      prev_mode_q        <= prev_mode_d;
      out_valid_q        <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o  = ~out_valid_q;
  assign result_o = out_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |-> !frame_take)
    else $error("frame taken while result slot is held");

  a_events_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.takeover && out_q.cancel))
    else $error("takeover and cancel raised together");

  a_takeover_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_take && takeover_fire) |=> (takeover_elapsed_q == '0))
    else $error("takeover counter not restarted after event");
`endif

endmodule
